FILE: design/imufp_pkg.sv
// Package for the IMU frame parser: frame constants, type codes and quantity encoding.
// Used by imufp_axis_scale, imu_frame_parser_core and the testbench; depends on nothing else.

package imufp_pkg;

    localparam int unsigned FRAME_LEN   = 11;
    localparam int unsigned SUM_LEN     = FRAME_LEN - 1;
    localparam int unsigned CNT_W       = $clog2(FRAME_LEN);
    localparam int unsigned RAW_W       = 16;
    localparam int unsigned AXIS_W      = 31;
    localparam int unsigned PROD_W      = 32;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_MASK   = 8'h50;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_GYRO   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;
    localparam logic [7:0] TYPE_MAG    = 8'h54;

    localparam logic signed [PROD_W-1:0] SCALE_ACCEL = 32'sd16;
    localparam logic signed [PROD_W-1:0] SCALE_GYRO  = 32'sd2000;
    localparam logic signed [PROD_W-1:0] SCALE_ANGLE = 32'sd180;
    localparam logic signed [PROD_W-1:0] SCALE_MAG   = 32'sd32768;

    typedef enum logic [1:0] {
        QTY_ACCEL = 2'd0,
        QTY_GYRO  = 2'd1,
        QTY_ANGLE = 2'd2,
        QTY_MAG   = 2'd3
    } qty_t;

endpackage

FILE: design/imufp_axis_scale.sv
// Scales one raw signed 16-bit axis word into Q.15 by the constant of its quantity.
// Depends on imufp_pkg for widths, scale constants and the quantity type.

module imufp_axis_scale
    import imufp_pkg::*;
(
    input  logic signed [RAW_W-1:0]  raw_word,
    input  qty_t                     qty,
    output logic signed [AXIS_W-1:0] scaled
);

    logic signed [PROD_W-1:0] raw_ext;
    logic signed [PROD_W-1:0] prod;

    assign raw_ext = PROD_W'(raw_word);

    // Every product is exact and fits in 31 signed bits.
    always_comb begin
        unique case (qty)
            QTY_ACCEL: prod = raw_ext * SCALE_ACCEL;
            QTY_GYRO:  prod = raw_ext * SCALE_GYRO;
            QTY_ANGLE: prod = raw_ext * SCALE_ANGLE;
            QTY_MAG:   prod = raw_ext * SCALE_MAG;
            default:   prod = '0;
        endcase
    end

    assign scaled = prod[AXIS_W-1:0];

endmodule

FILE: design/imu_frame_parser_core.sv
// Top level of the IMU serial frame parser: byte window, frame check, decode and output register.
// Depends on imufp_pkg and instantiates imufp_axis_scale three times.
//
//  Channel | Direction | Ports                                       | Transfer when
//  --------+-----------+---------------------------------------------+---------------------
//  s_      | in        | s_valid, s_ready, s_rx_byte                 | s_valid && s_ready
//  m_      | out       | m_valid, m_ready, m_status, m_quantity,     | m_valid && m_ready
//          |           | m_axis_x, m_axis_y, m_axis_z                |
//
// One byte is taken per cycle while s_ready is high. The window update and the frame check
// (header, type mask and the 8-bit sum of ten bytes) happen in the cycle of the transfer; the
// decision and the six data bytes go into a stage register, and the constant scaling fills the
// output register when the stage moves on. The input stalls only when both the stage register
// and the output register are full and m_ready is low. Reset clears the byte count and the
// valid flags; the window bytes are not cleared, since they are only read once all ten have
// been written.

module imu_frame_parser_core
    import imufp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_status,
    output logic [1:0]               m_quantity,
    output logic signed [AXIS_W-1:0] m_axis_x,
    output logic signed [AXIS_W-1:0] m_axis_y,
    output logic signed [AXIS_W-1:0] m_axis_z
);

    // Window and byte count.
    logic [7:0]       win_reg [SUM_LEN];
    logic [7:0]       win_next [SUM_LEN];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Stage register between check and scaling.
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_bad_reg;
    qty_t             s1_qty_reg;
    logic [7:0]       s1_data_reg [6];

    // Output register.
    logic                     m_valid_reg;
    logic                     m_status_reg;
    qty_t                     m_qty_reg;
    logic signed [AXIS_W-1:0] m_x_reg;
    logic signed [AXIS_W-1:0] m_y_reg;
    logic signed [AXIS_W-1:0] m_z_reg;

    logic       s_xfer;
    logic       out_free;
    logic       s1_move;
    logic       frame_full;
    logic [7:0] sum;
    logic       hdr_ok;
    logic       frame_good;
    logic       type_known;
    qty_t       type_qty;
    logic       emit;

    logic signed [AXIS_W-1:0] scl_x;
    logic signed [AXIS_W-1:0] scl_y;
    logic signed [AXIS_W-1:0] scl_z;

    // Handshake: the output register frees the stage, the stage frees the input.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_xfer   = s_valid && s_ready;

    // The incoming byte completes the frame when ten bytes are already held.
    assign frame_full = (cnt_reg == CNT_LAST);

    always_comb begin
        sum = '0;
        for (int k = 0; k < SUM_LEN; k++) begin
            sum = sum + win_reg[k];
        end
    end

    assign hdr_ok     = (win_reg[0] == HEADER_BYTE) &&
                        ((win_reg[1] & TYPE_MASK) == TYPE_MASK);
    assign frame_good = hdr_ok && (sum == s_rx_byte);

    always_comb begin
        type_known = 1'b1;
        type_qty   = QTY_ACCEL;
        unique case (win_reg[1])
            TYPE_ACCEL: type_qty = QTY_ACCEL;
            TYPE_GYRO:  type_qty = QTY_GYRO;
            TYPE_ANGLE: type_qty = QTY_ANGLE;
            TYPE_MAG:   type_qty = QTY_MAG;
            default:    type_known = 1'b0;
        endcase
    end

    // A full window gives a result when it is bad, or good with a known type.
    assign emit = frame_full && (!frame_good || type_known);

    // Window update. A bad frame shifts down by one byte and keeps ten; a good frame
    // empties the window, leaving the stale bytes to be overwritten.
    always_comb begin
        for (int k = 0; k < SUM_LEN; k++) begin
            win_next[k] = win_reg[k];
        end
        cnt_next = cnt_reg;
        if (s_xfer) begin
            if (!frame_full) begin
                for (int k = 0; k < SUM_LEN; k++) begin
                    if (cnt_reg == CNT_W'(k)) begin
                        win_next[k] = s_rx_byte;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
            end else if (!frame_good) begin
                for (int k = 0; k < SUM_LEN - 1; k++) begin
                    win_next[k] = win_reg[k + 1];
                end
                win_next[SUM_LEN-1] = s_rx_byte;
                cnt_next = CNT_LAST;
            end else begin
                cnt_next = '0;
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_xfer) begin
            s1_valid_next = emit;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < SUM_LEN; k++) begin
            win_reg[k] <= win_next[k];
        end
        if (s_xfer && emit) begin
            s1_bad_reg <= !frame_good;
            s1_qty_reg <= type_qty;
            for (int k = 0; k < 6; k++) begin
                s1_data_reg[k] <= win_reg[k + 2];
            end
        end
    end

    // Constant scaling of the three little-endian words.
    imufp_axis_scale u_scale_x (
        .raw_word ({s1_data_reg[1], s1_data_reg[0]}),
        .qty      (s1_qty_reg),
        .scaled   (scl_x)
    );

    imufp_axis_scale u_scale_y (
        .raw_word ({s1_data_reg[3], s1_data_reg[2]}),
        .qty      (s1_qty_reg),
        .scaled   (scl_y)
    );

    imufp_axis_scale u_scale_z (
        .raw_word ({s1_data_reg[5], s1_data_reg[4]}),
        .qty      (s1_qty_reg),
        .scaled   (scl_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // A bad frame reports zero quantity and zero axes.
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_status_reg <= s1_bad_reg;
            if (s1_bad_reg) begin
                m_qty_reg <= QTY_ACCEL;
                m_x_reg   <= '0;
                m_y_reg   <= '0;
                m_z_reg   <= '0;
            end else begin
                m_qty_reg <= s1_qty_reg;
                m_x_reg   <= scl_x;
                m_y_reg   <= scl_y;
                m_z_reg   <= scl_z;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_quantity = m_qty_reg;
    assign m_axis_x   = m_x_reg;
    assign m_axis_y   = m_y_reg;
    assign m_axis_z   = m_z_reg;

    // The byte count never passes the number of bytes the window can hold.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_LAST)
        else $error("byte count out of range");

    // A fresh stage entry comes only from a transfer that completed a frame.
    a_stage_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s1_valid_reg) |-> $past(s_valid && s_ready && cnt_reg == CNT_LAST))
        else $error("stage loaded without a completed frame");

    // A resync result carries zero quantity and zero axes.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |->
            (m_quantity == QTY_ACCEL && m_axis_x == '0 && m_axis_y == '0 && m_axis_z == '0))
        else $error("resync result with nonzero fields");

    // A byte that does not complete the window never produces a result.
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && cnt_reg != CNT_LAST) |=> !$rose(s1_valid_reg))
        else $error("result from an incomplete window");

endmodule

FILE: dv/tb_imu_frame_parser_core.sv
// Self-checking testbench for imu_frame_parser_core: byte stream in, decoded readings out.
// Depends on imufp_pkg and the RTL only. A built-in frame predictor checks every result transfer.
`timescale 1ns / 100ps

module tb_imu_frame_parser_core;
    import imufp_pkg::*;

    localparam int STALL_LIMIT   = 4000;  // cycles without any transfer before giving up
    localparam int PHASE_BYTES   = 500;
    localparam int DRAIN_CYCLES  = 8;     // settling time after the last reading before the final verdict

    // One decoded reading or resync notice, exactly as it leaves the m_ channel.
    typedef struct packed {
        logic                     status;
        qty_t                     quantity;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
    } reading_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic [7:0]               s_rx_byte = 8'h00;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic                     m_status;
    logic [1:0]               m_quantity;
    logic signed [AXIS_W-1:0] m_axis_x;
    logic signed [AXIS_W-1:0] m_axis_y;
    logic signed [AXIS_W-1:0] m_axis_z;

    logic [7:0]  byte_stream[$];        // bytes waiting to be offered on the s_ channel
    reading_t    expected_readings[$];  // readings predicted but not yet seen
    int unsigned send_idle_pct = 13;
    int unsigned recv_idle_pct = 63;
    int          fault_count   = 0;
    int          idle_cycles   = 0;

    // Predictor state: a copy of the receive window and its fill level.
    logic [7:0]  window_bytes[0:FRAME_LEN-1];
    int unsigned window_fill = 0;

    imu_frame_parser_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_quantity (m_quantity),
        .m_axis_x   (m_axis_x),
        .m_axis_y   (m_axis_y),
        .m_axis_z   (m_axis_z)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    function automatic logic signed [AXIS_W-1:0] scaled_axis(input logic [7:0] lo,
                                                             input logic [7:0] hi,
                                                             input int factor);
        logic signed [15:0] word;
        logic signed [31:0] product;
        word    = {hi, lo};
        product = word * factor;
        return product[AXIS_W-1:0];
    endfunction

    // Takes one accepted byte and queues the reading it causes, if any.
    task automatic absorb_byte(input logic [7:0] rx);
        logic [7:0] checksum;
        reading_t   reading;
        qty_t       qty;
        int         factor;
        int         k;
        if (window_fill >= FRAME_LEN)
            window_fill = 0;
        window_bytes[window_fill] = rx;
        window_fill++;
        if (window_fill < FRAME_LEN)
            return;

        checksum = 8'h00;
        for (k = 0; k < FRAME_LEN - 1; k++)
            checksum += window_bytes[k];

        reading = '0;
        if (window_bytes[0] != HEADER_BYTE || (window_bytes[1] & TYPE_MASK) != TYPE_MASK ||
            checksum != window_bytes[FRAME_LEN-1]) begin
            // Resync: drop the oldest byte and keep hunting with the other ten.
            for (k = 0; k < FRAME_LEN - 1; k++)
                window_bytes[k] = window_bytes[k+1];
            window_fill    = FRAME_LEN - 1;
            reading.status = 1'b1;
            expected_readings.push_back(reading);
            return;
        end

        window_fill = 0;
        case (window_bytes[1])
            TYPE_ACCEL: begin qty = QTY_ACCEL; factor = 16;    end
            TYPE_GYRO:  begin qty = QTY_GYRO;  factor = 2000;  end
            TYPE_ANGLE: begin qty = QTY_ANGLE; factor = 180;   end
            TYPE_MAG:   begin qty = QTY_MAG;   factor = 32768; end
            default:    return;  // valid frame of a type we do not decode
        endcase
        reading.status   = 1'b0;
        reading.quantity = qty;
        reading.axis_x   = scaled_axis(window_bytes[2], window_bytes[3], factor);
        reading.axis_y   = scaled_axis(window_bytes[4], window_bytes[5], factor);
        reading.axis_z   = scaled_axis(window_bytes[6], window_bytes[7], factor);
        expected_readings.push_back(reading);
    endtask

    task automatic note_fault(input string what, input reading_t want, input reading_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s  expected st=%0d q=%0d x=%0d y=%0d z=%0d  got st=%0d q=%0d x=%0d y=%0d z=%0d",
                     $realtime, what, want.status, want.quantity, want.axis_x, want.axis_y,
                     want.axis_z, got.status, got.quantity, got.axis_x, got.axis_y, got.axis_z);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    // Queues one 11-byte frame. The checksum byte is XORed with sum_flip, so a nonzero
    // flip gives a checksum error.
    task automatic queue_frame(input logic [7:0] header, input logic [7:0] kind,
                               input logic [15:0] wx, input logic [15:0] wy,
                               input logic [15:0] wz, input logic [15:0] w4,
                               input logic [7:0] sum_flip);
        logic [7:0] body[0:FRAME_LEN-2];
        logic [7:0] checksum;
        int         k;
        body = '{header, kind, wx[7:0], wx[15:8], wy[7:0], wy[15:8],
                 wz[7:0], wz[15:8], w4[7:0], w4[15:8]};
        checksum = 8'h00;
        for (k = 0; k < FRAME_LEN - 1; k++) begin
            checksum += body[k];
            byte_stream.push_back(body[k]);
        end
        byte_stream.push_back(checksum ^ sum_flip);
    endtask

    // Words lean toward the signed extremes so the scaled products hit their limits.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] known_kind();
        case ($urandom_range(3))
            0:       return TYPE_ACCEL;
            1:       return TYPE_GYRO;
            2:       return TYPE_ANGLE;
            default: return TYPE_MAG;
        endcase
    endfunction

    // Mostly clean frames with random content; the rest are undecoded types, corrupted
    // frames, cut-off frames and loose noise bytes that force the parser to resync.
    task automatic queue_random_traffic(input int byte_total);
        logic [7:0]  kind;
        logic [7:0]  header;
        logic [7:0]  flip;
        int unsigned pick;
        int          start;
        int          n;
        start = byte_stream.size();
        while (byte_stream.size() - start < byte_total) begin
            pick = $urandom_range(99);
            if (pick < 66) begin
                queue_frame(HEADER_BYTE, known_kind(), pick_word(), pick_word(), pick_word(),
                            16'($urandom), 8'h00);
            end else if (pick < 74) begin
                do kind = TYPE_MASK | 8'($urandom);
                while (kind inside {TYPE_ACCEL, TYPE_GYRO, TYPE_ANGLE, TYPE_MAG});
                queue_frame(HEADER_BYTE, kind, pick_word(), pick_word(), pick_word(),
                            16'($urandom), 8'h00);
            end else if (pick < 86) begin
                header = HEADER_BYTE;
                kind   = known_kind();
                flip   = 8'h00;
                case ($urandom_range(2))
                    0: do header = 8'($urandom); while (header == HEADER_BYTE);
                    1: kind = kind & ~(($urandom_range(1) != 0) ? 8'h40 : 8'h10);
                    default: flip = 8'($urandom_range(1, 255));
                endcase
                queue_frame(header, kind, pick_word(), pick_word(), pick_word(),
                            16'($urandom), flip);
            end else if (pick < 92) begin
                // A frame cut short: only its first few bytes make it onto the line.
                queue_frame(HEADER_BYTE, known_kind(), pick_word(), pick_word(), pick_word(),
                            16'($urandom), 8'h00);
                n = $urandom_range(1, FRAME_LEN - 1);
                repeat (n) void'(byte_stream.pop_back());
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) byte_stream.push_back(8'($urandom));
            end
        end
    endtask

    // Holds off until every queued byte has been taken and every reading has come back.
    task automatic wait_drained();
        do @(negedge aclk);
        while (byte_stream.size() != 0 || s_valid || expected_readings.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------

    // The payload only moves on once the current byte has been transferred.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid   <= 1'b1;
                s_rx_byte <= byte_stream.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        reading_t got;
        reading_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                absorb_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                got = '{m_status, qty_t'(m_quantity), m_axis_x, m_axis_y, m_axis_z};
                if (expected_readings.size() == 0) begin
                    note_fault("unexpected reading", '0, got);
                end else begin
                    want = expected_readings.pop_front();
                    if (got !== want)
                        note_fault("reading mismatch", want, got);
                end
            end
        end
    end

    // Watchdog: any transfer on either channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames: every decoded type with the word extremes, undecoded types,
        // each kind of frame error, and a clean frame to confirm the parser resyncs.
        queue_frame(HEADER_BYTE, TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 8'h00);
        queue_frame(HEADER_BYTE, TYPE_GYRO,  16'hFFFF, 16'h0001, 16'h7FFF, 16'h0000, 8'h00);
        queue_frame(HEADER_BYTE, TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h5A5A, 8'h00);
        queue_frame(HEADER_BYTE, TYPE_MAG,   16'h7FFF, 16'h8000, 16'h0001, 16'hA5A5, 8'h00);
        queue_frame(HEADER_BYTE, TYPE_MASK,  16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 8'h00);
        queue_frame(HEADER_BYTE, 8'hFF,      16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 8'h00);
        queue_frame(8'hAA,       TYPE_ACCEL, 16'h0100, 16'h0200, 16'h0300, 16'h0000, 8'h00);
        queue_frame(HEADER_BYTE, 8'h41,      16'h0100, 16'h0200, 16'h0300, 16'h0000, 8'h00);
        queue_frame(HEADER_BYTE, TYPE_GYRO,  16'h0100, 16'h0200, 16'h0300, 16'h0000, 8'h80);
        queue_frame(HEADER_BYTE, TYPE_ANGLE, 16'h4000, 16'hC000, 16'h0042, 16'h0000, 8'h00);

        // Slow receiver, busy sender.
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        // Slow sender, busy receiver. The drain above doubles as a full pause of the sender.
        send_idle_pct = 63;
        recv_idle_pct = 13;
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        // Both sides at full rate.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_traffic(PHASE_BYTES);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0 && expected_readings.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/imufp_pkg.sv
design/imufp_axis_scale.sv
design/imu_frame_parser_core.sv
dv/tb_imu_frame_parser_core.sv
